@@ rtl/core/gain_scheduled_pi_controller_defines.svh @@
// Assertion macros shared by the checker files of the PI controller.
`ifndef GAIN_SCHEDULED_PI_CONTROLLER_DEFINES_SVH
`define GAIN_SCHEDULED_PI_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GSPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define GSPI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/gspi_pkg.sv @@
// Types, constants and codes of the gain scheduled PI controller.
`timescale 1ns / 1ps
package gspi_pkg;

  localparam int NUM_POINTS = 4;
  localparam int NUM_SCHED_REGS = 4;
  localparam int SEG_W = $clog2(NUM_POINTS);

  localparam int RPM_W = 16;
  localparam int GAIN_W = 16;
  localparam int DT_W = 16;
  localparam int PWM_W = 16;
  localparam int SCHED_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam int INT_W = 48;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 16;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam int DIV_N_W = 40;
  localparam int DIV_D_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam int SUM_W = 66;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PWM = 3'd4;
  localparam logic [PWM_W-1:0] MAX_PWM_RESET = 16'd255;

  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [RPM_W-1:0] speed_target;
    logic [RPM_W-1:0] measured_rpm;
    logic [DT_W-1:0]  time_step;
  } gspi_req_t;

  typedef struct packed {
    logic [PWM_W-1:0]  pwm_out;
    logic [GAIN_W-1:0] kp_used;
    logic [GAIN_W-1:0] ki_used;
  } gspi_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMUL,
    ST_KPMUL,
    ST_KPDIV,
    ST_KIMUL,
    ST_KIDIV,
    ST_BOUND,
    ST_PMUL,
    ST_IMUL,
    ST_SUM,
    ST_OUT
  } gspi_state_t;

endpackage

@@ rtl/core/gain_scheduled_pi_controller.sv @@
// Path to out_valid: clear, idle and skip transactions go from the prepare state straight to
// the output state; compute runs the error multiply, the bound divide when Ki is nonzero, and
// the P and I multiplies, plus two serial multiplies and two serial divides when the gains are interpolated.
// One transaction at a time: the next is accepted in the cycle after the result is
// registered; a stalled result holds the engine in its output state.
// Reset (synchronous, active low): integral and gains zero, schedule zero, max_pwm 255.
`timescale 1ns / 1ps
module gain_scheduled_pi_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gspi_pkg::gspi_req_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gspi_pkg::gspi_rsp_t              out_data,
  input  logic                             cfg_we,
  input  logic [gspi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gspi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gspi_pkg::*;

  gspi_state_t state_r, state_nxt;
  logic        launch_r;

  logic [SCHED_W-1:0] sched_r [NUM_SCHED_REGS];
  logic [PWM_W-1:0]   max_pwm_r;

  gspi_req_t          req_r;
  logic [INT_W-1:0]   integral_r;
  logic [INT_W-1:0]   acc_r;
  logic [GAIN_W-1:0]  kp_cur_r, ki_cur_r;
  logic               err_neg_r;
  logic [RPM_W-1:0]   err_mag_r;
  logic               interp_r;
  logic [RPM_W-1:0]   num_r, den_r;
  logic [GAIN_W-1:0]  kp_lo_r, ki_lo_r, kp_dmag_r, ki_dmag_r;
  logic               kp_dneg_r, ki_dneg_r;
  logic [PROD_W-1:0]  mprod_r;
  logic [SUM_W-1:0]   sum_r;
  logic [PWM_W-1:0]   pwm_r;
  gspi_rsp_t          out_r;
  logic               out_valid_r;

  logic [RPM_W-1:0]   pt_rpm [NUM_POINTS];
  logic [GAIN_W-1:0]  pt_kp  [NUM_POINTS];
  logic [GAIN_W-1:0]  pt_ki  [NUM_POINTS];

  logic               seg_found;
  logic [RPM_W-1:0]   lo_rpm, hi_rpm;
  logic [GAIN_W-1:0]  lo_kp, hi_kp, lo_ki, hi_ki;

  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_prod;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic [DIV_N_W-1:0] div_q;

  logic [RPM_W:0]     err_full;
  logic [INT_W:0]     ep_ext, acc_sum;
  logic [INT_W-1:0]   bound_ext, bound_neg, int_mag;
  logic [GAIN_W-1:0]  q_gain;
  logic [SUM_W-1:0]   term_p, term_i;
  logic               out_free;

  for (genvar g = 0; g < NUM_POINTS; g++) begin : g_pts
    assign pt_rpm[g] = sched_r[g][47:32];
    assign pt_kp[g]  = sched_r[g][31:16];
    assign pt_ki[g]  = sched_r[g][15:0];
  end

  // First segment that holds the setpoint.
  always_comb begin
    seg_found = 1'b0;
    lo_rpm = '0;
    hi_rpm = '0;
    lo_kp  = '0;
    hi_kp  = '0;
    lo_ki  = '0;
    hi_ki  = '0;
    for (int i = 0; i < NUM_POINTS - 1; i++) begin
      if (!seg_found && req_r.speed_target >= pt_rpm[i] &&
          req_r.speed_target <= pt_rpm[i+1]) begin
        seg_found = 1'b1;
        lo_rpm = pt_rpm[i];
        hi_rpm = pt_rpm[i+1];
        lo_kp  = pt_kp[i];
        hi_kp  = pt_kp[i+1];
        lo_ki  = pt_ki[i];
        hi_ki  = pt_ki[i+1];
      end
    end
  end

  assign err_full = {1'b0, req_r.speed_target} - {1'b0, req_r.measured_rpm};
  assign ep_ext   = err_neg_r ? -{17'b0, mul_prod[31:0]} : {17'b0, mul_prod[31:0]};
  assign acc_sum  = {integral_r[INT_W-1], integral_r} + ep_ext;
  assign bound_ext = {8'b0, div_q};
  assign bound_neg = -bound_ext;
  assign int_mag   = integral_r[INT_W-1] ? -integral_r : integral_r;
  assign q_gain    = div_q[GAIN_W-1:0];
  assign term_p = err_neg_r ? -{17'b0, mprod_r[32:0], 16'b0} : {17'b0, mprod_r[32:0], 16'b0};
  assign term_i = integral_r[INT_W-1] ? -{2'b0, mul_prod} : {2'b0, mul_prod};
  assign out_free = !out_valid_r || !out_stall;

  // Operand selection for the shared serial units.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    case (state_r)
      ST_EMUL: begin
        mul_a = {32'b0, err_mag_r};
        mul_b = req_r.time_step;
      end
      ST_KPMUL: begin
        mul_a = {32'b0, kp_dmag_r};
        mul_b = num_r;
      end
      ST_KIMUL: begin
        mul_a = {32'b0, ki_dmag_r};
        mul_b = num_r;
      end
      ST_PMUL: begin
        mul_a = {32'b0, err_mag_r};
        mul_b = kp_cur_r;
      end
      ST_IMUL: begin
        mul_a = int_mag;
        mul_b = ki_cur_r;
      end
      ST_KPDIV, ST_KIDIV: begin
        div_n = mprod_r[DIV_N_W-1:0];
        div_d = den_r;
      end
      ST_BOUND: begin
        div_n = {max_pwm_r, 24'b0};
        div_d = ki_cur_r;
      end
      default: ;
    endcase
  end

  assign mul_start = launch_r && (state_r inside {ST_EMUL, ST_KPMUL, ST_KIMUL, ST_PMUL, ST_IMUL});
  assign div_start = launch_r && ((state_r inside {ST_KPDIV, ST_KIDIV}) ||
                                  (state_r == ST_BOUND && ki_cur_r != '0));

  gspi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  gspi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PREP;
      ST_PREP: begin
        if (req_r.opcode == OP_CLEAR || req_r.speed_target == '0 ||
            req_r.time_step == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_EMUL;
        end
      end
      ST_EMUL:  if (mul_done) state_nxt = interp_r ? ST_KPMUL : ST_BOUND;
      ST_KPMUL: if (mul_done) state_nxt = ST_KPDIV;
      ST_KPDIV: if (div_done) state_nxt = ST_KIMUL;
      ST_KIMUL: if (mul_done) state_nxt = ST_KIDIV;
      ST_KIDIV: if (div_done) state_nxt = ST_BOUND;
      ST_BOUND: if (ki_cur_r == '0 || div_done) state_nxt = ST_PMUL;
      ST_PMUL:  if (mul_done) state_nxt = ST_IMUL;
      ST_IMUL:  if (mul_done) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= (state_nxt != state_r);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SCHED_REGS; i++) sched_r[i] <= '0;
      max_pwm_r <= MAX_PWM_RESET;
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_W'(NUM_SCHED_REGS)) begin
        sched_r[cfg_index[1:0]] <= cfg_wdata;
      end else if (cfg_index == CFG_MAX_PWM) begin
        max_pwm_r <= cfg_wdata[PWM_W-1:0];
      end
    end
  end

  // Controller state and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      kp_cur_r   <= '0;
      ki_cur_r   <= '0;
      interp_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: if (in_valid) req_r <= in_data;
        ST_PREP: begin
          pwm_r     <= '0;
          interp_r  <= 1'b0;
          err_neg_r <= err_full[RPM_W];
          err_mag_r <= err_full[RPM_W] ? -err_full[RPM_W-1:0] : err_full[RPM_W-1:0];
          if (req_r.opcode == OP_CLEAR) begin
            integral_r <= '0;
          end else if (req_r.speed_target != '0 && req_r.time_step != '0) begin
            if (req_r.speed_target <= pt_rpm[0]) begin
              kp_cur_r <= pt_kp[0];
              ki_cur_r <= pt_ki[0];
            end else if (req_r.speed_target >= pt_rpm[NUM_POINTS-1]) begin
              kp_cur_r <= pt_kp[NUM_POINTS-1];
              ki_cur_r <= pt_ki[NUM_POINTS-1];
            end else if (seg_found) begin
              if (hi_rpm == lo_rpm) begin
                kp_cur_r <= lo_kp;
                ki_cur_r <= lo_ki;
              end else begin
                interp_r  <= 1'b1;
                num_r     <= req_r.speed_target - lo_rpm;
                den_r     <= hi_rpm - lo_rpm;
                kp_lo_r   <= lo_kp;
                ki_lo_r   <= lo_ki;
                kp_dneg_r <= hi_kp < lo_kp;
                ki_dneg_r <= hi_ki < lo_ki;
                kp_dmag_r <= (hi_kp < lo_kp) ? lo_kp - hi_kp : hi_kp - lo_kp;
                ki_dmag_r <= (hi_ki < lo_ki) ? lo_ki - hi_ki : hi_ki - lo_ki;
              end
            end
          end
        end
        ST_EMUL: begin
          // Saturate the new integral to the signed 48-bit range.
          if (mul_done) begin
            if (acc_sum[INT_W] != acc_sum[INT_W-1]) begin
              acc_r <= acc_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
            end else begin
              acc_r <= acc_sum[INT_W-1:0];
            end
          end
        end
        ST_KPMUL, ST_KIMUL: if (mul_done) mprod_r <= mul_prod;
        ST_KPDIV: if (div_done) kp_cur_r <= kp_dneg_r ? kp_lo_r - q_gain : kp_lo_r + q_gain;
        ST_KIDIV: if (div_done) ki_cur_r <= ki_dneg_r ? ki_lo_r - q_gain : ki_lo_r + q_gain;
        ST_BOUND: begin
          // Anti-windup clamp to the bound max_pwm * 2^24 / Ki.
          if (ki_cur_r == '0) begin
            integral_r <= acc_r;
          end else if (div_done) begin
            if ($signed(acc_r) > $signed(bound_ext)) begin
              integral_r <= bound_ext;
            end else if ($signed(acc_r) < $signed(bound_neg)) begin
              integral_r <= bound_neg;
            end else begin
              integral_r <= acc_r;
            end
          end
        end
        ST_PMUL: if (mul_done) mprod_r <= mul_prod;
        ST_IMUL: if (mul_done) sum_r <= term_p + term_i;
        ST_SUM: begin
          if (sum_r[SUM_W-1] || sum_r == '0) begin
            pwm_r <= '0;
          end else if (sum_r[SUM_W-2:40] != '0 || sum_r[39:24] > max_pwm_r) begin
            pwm_r <= max_pwm_r;
          end else begin
            pwm_r <= sum_r[39:24];
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: hold the result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
      out_r <= '{pwm_out: pwm_r, kp_used: kp_cur_r, ki_used: ki_cur_r};
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/gspi_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module gspi_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [gspi_pkg::MUL_A_W-1:0]   a,
  input  logic [gspi_pkg::MUL_B_W-1:0]   b,
  output logic                           done,
  output logic [gspi_pkg::PROD_W-1:0]    prod
);
  import gspi_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_A_W-1:0]   a_r;
  logic [PROD_W-1:0]    p_r;
  logic [MUL_A_W:0]     part_sum;

  // Add the multiplicand into the upper half when the low bit is set, then shift.
  assign part_sum = {1'b0, p_r[PROD_W-1:MUL_B_W]} + (p_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a;
        p_r    <= {{MUL_A_W{1'b0}}, b};
      end else if (busy_r) begin
        p_r   <= {part_sum, p_r[MUL_B_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

@@ rtl/core/gspi_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gspi_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gspi_pkg::DIV_N_W-1:0]  dividend,
  input  logic [gspi_pkg::DIV_D_W-1:0]  divisor,
  output logic                          done,
  output logic [gspi_pkg::DIV_N_W-1:0]  quot
);
  import gspi_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W-1:0]   dvs_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_N_W-1:0]   q_r;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 ge;

  // Remainder stays below the divisor, so the trial fits one bit wider.
  assign trial = {rem_r, q_r[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvs_r  <= divisor;
        rem_r  <= '0;
        q_r    <= dividend;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        q_r   <= {q_r[DIV_N_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ rtl/core/gspi_checker.sv @@
// Port-level checks of the PI controller, bound to the top level.
`timescale 1ns / 1ps
`include "gain_scheduled_pi_controller_defines.svh"
module gspi_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input gspi_pkg::gspi_rsp_t  out_data
);
  import gspi_pkg::*;

  `GSPI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, $stable(out_data) && out_valid)
  `GSPI_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `GSPI_ASSERT_IMP(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))
  `GSPI_ASSERT_NXT(a_no_result_from_idle, clk, rst_n, !in_stall, !$rose(out_valid))

endmodule

bind gain_scheduled_pi_controller gspi_checker u_gspi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ sim/gain_scheduled_pi_controller_tb.sv @@
// Self-checking testbench of the gain scheduled PI speed controller.
`timescale 1ns / 1ps
module gain_scheduled_pi_controller_tb;
  import gspi_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gspi_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gspi_rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gain_scheduled_pi_controller i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Controller shadow state
  logic [SCHED_W-1:0] sched_shadow [NUM_SCHED_REGS];
  logic [PWM_W-1:0] max_pwm_shadow;
  longint signed integral_shadow;
  logic [GAIN_W-1:0] kp_shadow, ki_shadow;

  gspi_rsp_t pwm_expected [$];
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0, checked_count = 0, cfg_count = 0;
  int unsigned idle_cycles = 0;

  function automatic longint pt_rpm(int i);
    return longint'(sched_shadow[i][47:32]);
  endfunction
  function automatic longint pt_kp(int i);
    return longint'(sched_shadow[i][31:16]);
  endfunction
  function automatic longint pt_ki(int i);
    return longint'(sched_shadow[i][15:0]);
  endfunction

  function automatic logic [GAIN_W-1:0] lerp(longint lo, longint hi, longint num,
                                              longint den);
    longint v;
    v = lo + ((hi - lo) * num) / den;
    return v[15:0];
  endfunction

  task automatic pick_gains(longint sp);
    int last;
    last = NUM_POINTS - 1;
    if (sp <= pt_rpm(0)) begin
      kp_shadow = 16'(pt_kp(0));
      ki_shadow = 16'(pt_ki(0));
      return;
    end
    if (sp >= pt_rpm(last)) begin
      kp_shadow = 16'(pt_kp(last));
      ki_shadow = 16'(pt_ki(last));
      return;
    end
    for (int i = 0; i < last; i++) begin
      if (sp >= pt_rpm(i) && sp <= pt_rpm(i + 1)) begin
        if (pt_rpm(i + 1) == pt_rpm(i)) begin
          kp_shadow = 16'(pt_kp(i));
          ki_shadow = 16'(pt_ki(i));
        end else begin
          kp_shadow = lerp(pt_kp(i), pt_kp(i + 1), sp - pt_rpm(i),
                           pt_rpm(i + 1) - pt_rpm(i));
          ki_shadow = lerp(pt_ki(i), pt_ki(i + 1), sp - pt_rpm(i),
                           pt_rpm(i + 1) - pt_rpm(i));
        end
        return;
      end
    end
  endtask

  task automatic predict_pwm(input gspi_req_t req);
    longint signed err, acc, bound, sum, pwm;
    longint signed imax;
    gspi_rsp_t rsp;
    imax = 64'sh7FFF_FFFF_FFFF;
    pwm = 0;
    if (req.opcode == OP_CLEAR) begin
      integral_shadow = 0;
    end else if (req.speed_target != 0 && req.time_step != 0) begin
      err = longint'(req.speed_target) - longint'(req.measured_rpm);
      acc = integral_shadow + err * longint'(req.time_step);
      if (acc > imax) acc = imax;
      if (acc < -imax - 1) acc = -imax - 1;
      pick_gains(longint'(req.speed_target));
      if (ki_shadow != 0) begin
        bound = (longint'(max_pwm_shadow) << 24) / longint'(ki_shadow);
        if (acc > bound) acc = bound;
        else if (acc < -bound) acc = -bound;
      end
      integral_shadow = acc;
      sum = longint'(kp_shadow) * err * 65536 + longint'(ki_shadow) * acc;
      if (sum > 0) begin
        pwm = sum >>> 24;
        if (pwm > longint'(max_pwm_shadow)) pwm = longint'(max_pwm_shadow);
      end
    end
    rsp.pwm_out = pwm[15:0];
    rsp.kp_used = kp_shadow;
    rsp.ki_used = ki_shadow;
    pwm_expected.push_back(rsp);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             checked_count);
  endtask

  // Result checker with random receiver stalls
  always @(posedge clk) begin
    gspi_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pwm_expected.size() == 0) begin
        report_mismatch("unexpected result", out_data.pwm_out, 16'd0);
      end else begin
        want = pwm_expected.pop_front();
        if (out_data.pwm_out !== want.pwm_out)
          report_mismatch("pwm_out", out_data.pwm_out, want.pwm_out);
        if (out_data.kp_used !== want.kp_used)
          report_mismatch("kp_used", out_data.kp_used, want.kp_used);
        if (out_data.ki_used !== want.ki_used)
          report_mismatch("ki_used", out_data.ki_used, want.ki_used);
      end
      checked_count++;
    end
  end

  int unsigned stall_left = 0;
  bit stall_quiet = 1'b0;
  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left <= stall_quiet ? 0 : $urandom_range(0, 15);
    if (stall_quiet) out_stall <= 1'b0;
    else if (out_valid && !out_stall) out_stall <= ($urandom_range(0, 15) != 0)
                                                  && !stall_quiet;
    else if (out_stall) begin
      if (stall_left == 0) out_stall <= 1'b0;
      else stall_left <= stall_left - 1;
    end
  end

  // Watchdog on accepted transactions, results and register writes
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pwm_expected.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  bit sender_quiet = 1'b0;

  task automatic send_item(input gspi_req_t req);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 15);
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    predict_pwm(req);
    sent_count++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pwm_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_SCHED_REGS) sched_shadow[idx] = val;
    else if (idx == CFG_MAX_PWM) max_pwm_shadow = val[15:0];
    cfg_count++;
    @(posedge clk);
  endtask

  function automatic logic [47:0] pack_point(logic [15:0] rpm, logic [15:0] kp,
                                             logic [15:0] ki);
    return {rpm, kp, ki};
  endfunction

  function automatic gspi_req_t make_req(logic op, logic [15:0] sp, logic [15:0] ms,
                                         logic [15:0] dt);
    gspi_req_t r;
    r.opcode = op;
    r.speed_target = sp;
    r.measured_rpm = ms;
    r.time_step = dt;
    return r;
  endfunction

  // Random schedule; when ordered it is ascending and sometimes has a repeated rpm point
  task automatic load_schedule(input bit ordered);
    logic [15:0] rpm [4];
    for (int i = 0; i < 4; i++) rpm[i] = $urandom_range(0, 65535);
    if (ordered) rpm.sort();
    if (ordered && $urandom_range(0, 3) == 0) rpm[2] = rpm[1];
    for (int i = 0; i < 4; i++)
      write_cfg(CFG_SCHED_0 + 3'(i), pack_point(rpm[i], 16'($urandom), 16'($urandom)));
  endtask

  task automatic test_reset_state;
    send_item(make_req(OP_COMPUTE, 16'd1000, 16'd0, 16'd100));
    send_item(make_req(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    drain();
  endtask

  task automatic test_directed;
    write_cfg(CFG_SCHED_0 + 3'd0, pack_point(16'd1000, 16'h0100, 16'h0080));
    write_cfg(CFG_SCHED_0 + 3'd1, pack_point(16'd2000, 16'h0400, 16'h0200));
    write_cfg(CFG_SCHED_0 + 3'd2, pack_point(16'd2000, 16'h0800, 16'h0010));
    write_cfg(CFG_SCHED_0 + 3'd3, pack_point(16'd60000, 16'hFFFF, 16'hFFFF));
    write_cfg(CFG_MAX_PWM, 48'd1000);
    write_cfg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
    send_item(make_req(OP_COMPUTE, 16'd500, 16'd0, 16'hFFFF));
    send_item(make_req(OP_COMPUTE, 16'd1500, 16'd1400, 16'd1000));
    send_item(make_req(OP_COMPUTE, 16'd2000, 16'd2100, 16'd1));
    send_item(make_req(OP_COMPUTE, 16'd30000, 16'd65535, 16'hFFFF));
    send_item(make_req(OP_COMPUTE, 16'hFFFF, 16'd0, 16'hFFFF));
    send_item(make_req(OP_COMPUTE, 16'd0, 16'd100, 16'd100));
    send_item(make_req(OP_COMPUTE, 16'd1200, 16'd100, 16'd0));
    send_item(make_req(OP_CLEAR, 16'd1200, 16'd100, 16'd100));
    send_item(make_req(OP_COMPUTE, 16'd1000, 16'd1000, 16'd5));
    drain();
    // Ki zero: the integral is not clamped
    write_cfg(CFG_SCHED_0 + 3'd3, pack_point(16'd100, 16'h0000, 16'h0000));
    write_cfg(CFG_SCHED_0 + 3'd0, pack_point(16'd10, 16'h0000, 16'h0000));
    write_cfg(CFG_MAX_PWM, 48'd65535);
    send_item(make_req(OP_COMPUTE, 16'hFFFF, 16'd0, 16'hFFFF));
    send_item(make_req(OP_COMPUTE, 16'd200, 16'hFFFF, 16'hFFFF));
    drain();
    // Unordered schedule: setpoint between the end points, inside the first segment
    write_cfg(CFG_SCHED_0 + 3'd1, pack_point(16'd5000, 16'h0300, 16'h0003));
    write_cfg(CFG_SCHED_0 + 3'd2, pack_point(16'd6000, 16'h0200, 16'h0002));
    write_cfg(CFG_SCHED_0 + 3'd3, pack_point(16'd200, 16'h0100, 16'h0001));
    send_item(make_req(OP_COMPUTE, 16'd150, 16'd10, 16'd300));
    send_item(make_req(OP_CLEAR, 16'd0, 16'd0, 16'd0));
    drain();
  endtask

  task automatic test_random_phase(input int n, input logic [15:0] max_pwm_val,
                                   input bit ordered);
    gspi_req_t r;
    int unsigned sel;
    load_schedule(ordered);
    write_cfg(CFG_MAX_PWM, 48'(max_pwm_val));
    for (int k = 0; k < n; k++) begin
      r = make_req(OP_COMPUTE, 16'($urandom), 16'($urandom), 16'($urandom));
      sel = $urandom_range(0, 19);
      if (sel == 0) r.opcode = OP_CLEAR;
      else if (sel == 1) r.speed_target = '0;
      else if (sel == 2) r.time_step = '0;
      else if (sel < 10) r.measured_rpm = r.speed_target + 16'($urandom_range(0, 400)) - 16'd200;
      if (sel >= 10 && sel < 14) r.time_step = 16'($urandom_range(1, 255));
      send_item(r);
    end
  endtask

  task automatic test_backlog_pause;
    // Send back to back with no stalls, then pause until everything is back
    sender_quiet = 1'b1;
    stall_quiet = 1'b1;
    for (int k = 0; k < 20; k++)
      send_item(make_req(OP_COMPUTE, 16'($urandom), 16'($urandom), 16'($urandom)));
    drain();
    sender_quiet = 1'b0;
    stall_quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NUM_SCHED_REGS; i++) sched_shadow[i] = '0;
    max_pwm_shadow = MAX_PWM_RESET;
    integral_shadow = 0;
    kp_shadow = '0;
    ki_shadow = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random_phase(150, 16'd255, 1'b1);
    drain();
    test_random_phase(150, 16'hFFFF, 1'b1);
    drain();
    test_random_phase(150, 16'd0, 1'b1);
    drain();
    test_backlog_pause();
    test_random_phase(60, 16'd1, 1'b0);
    drain();
    test_random_phase(100, 16'($urandom), 1'b1);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d transactions, %0d results checked, %0d register writes",
             sent_count, checked_count, cfg_count);
    $display("phases: reset state, directed corners, random schedules, max_pwm 0/1/255/65535");
    if (mismatch_count == 0 && pwm_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pwm_expected.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
